// ----- hw/rtl/ghpq_pkg.sv -----
// ----------------------------------------------------------------------------
// ghpq_pkg
// Shared types and constants for the gravity heap priority queue.
// ----------------------------------------------------------------------------
package ghpq_pkg;

	localparam int unsigned DefCapacity = 64;
	localparam int unsigned DefTagWidth = 32;
	localparam int unsigned PrioWidth   = 64;

	typedef enum logic [2:0] {
		OP_INSERT  = 3'd0,
		OP_REMOVE  = 3'd1,
		OP_PEEK    = 3'd2,
		OP_CONTAIN = 3'd3,
		OP_REGRAV  = 3'd4,
		OP_CLEAR   = 3'd5,
		OP_NOP6    = 3'd6,
		OP_NOP7    = 3'd7
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_PEEK_TAG,
		S_REM_TAG,
		S_REM_LOAD,
		S_UP_RD,
		S_UP_CMP,
		S_DN_L,
		S_DN_R,
		S_DN_PICK,
		S_DN_CMP,
		S_CON_RD,
		S_CON_CMP,
		S_RG_NEXT,
		S_RG_LOAD,
		S_DONE
	} state_t;

	// Controller to datapath commands. Read address defaults to the root.
	typedef struct packed {
		logic       load_req;    // capture input request
		logic       ins_setup;   // X := new entry, cur := count, count++
		logic       set_empty;
		logic       set_full;
		logic       take_tag;    // result tag := tag just read
		logic       rem_last;    // read last entry, count--
		logic       x_load;      // X := entry just read
		logic       cur_root;    // cur := 0
		logic       cur_start;   // cur := rebuild index
		logic       rd_par;      // read parent of cur
		logic       up_move;     // write parent into cur, cur := parent
		logic       wr_x;        // write X into cur
		logic       rd_left;     // read left child
		logic       take_left;   // B := left child
		logic       rd_right;    // read right child
		logic       take_right;  // B := right child
		logic       dn_move;     // write B into cur, cur := pick
		logic       con_setup;   // scan index := 0
		logic       con_rd;      // read tag at scan index
		logic       con_step;    // note match, scan index++
		logic       rg_setup;    // set gravity, rebuild index := count
		logic       rg_dec;      // rebuild index--, read that entry
		logic       clr;         // count := 0
		logic       out_load;    // load result register
	} ghpq_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		opcode_t op;
		logic    empty;
		logic    full;
		logic    cur_zero;      // sift up reached root
		logic    par_farther;   // dist(parent read) > dist(X)
		logic    has_left;      // left child exists
		logic    has_right;     // right child exists
		logic    right_closer;  // dist(right read) < dist(B)
		logic    x_farther;     // dist(X) > dist(B)
		logic    con_end;       // scan index reached count
		logic    con_hit;       // tag read matches
		logic    rg_end;        // rebuild index is zero
	} ghpq_sts_t;

endpackage

// ----- hw/rtl/ghpq_datapath.sv -----
// ----------------------------------------------------------------------------
// ghpq_datapath
// Heap memory, index registers, distance compare and result register.
// ----------------------------------------------------------------------------
module ghpq_datapath import ghpq_pkg::*; #(
	parameter int unsigned CAPACITY  = DefCapacity,
	parameter int unsigned TAG_WIDTH = DefTagWidth
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ghpq_cmd_t             cmd,
	output ghpq_sts_t             sts,
	input  logic [2:0]            opcode,
	input  logic [PrioWidth-1:0]  priority_req,
	input  logic [31:0]           value_tag,
	input  logic [PrioWidth-1:0]  new_gravity,
	output logic                  out_valid_set,
	output logic [1:0]            status,
	output logic [31:0]           result_tag,
	output logic                  found,
	output logic [6:0]            count
);

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned IW = AW + 2;
	localparam int unsigned EW = PrioWidth + TAG_WIDTH;

	logic [EW-1:0] mem [CAPACITY];

	opcode_t              op_q;
	logic [PrioWidth-1:0] prio_q;
	logic [TAG_WIDTH-1:0] tag_q;
	logic [PrioWidth-1:0] ngrav_q;
	logic [PrioWidth-1:0] grav_q;
	logic [CW-1:0]        cnt_q;
	logic [AW-1:0]        cur_q;
	logic [AW-1:0]        pick_q;
	logic [CW-1:0]        start_q;
	logic [CW-1:0]        scan_q;
	logic [EW-1:0]        ent_x_q;
	logic [EW-1:0]        ent_b_q;
	logic [EW-1:0]        rd_q;
	logic [TAG_WIDTH-1:0] rtag_q;
	logic                 found_q;
	logic [1:0]           st_q;

	logic                 we;
	logic [EW-1:0]        wd;
	logic [AW-1:0]        ra;

	logic [IW-1:0]        lidx;
	logic [IW-1:0]        ridx;
	logic [AW-1:0]        par;
	logic [PrioWidth-1:0] dist_x;
	logic [PrioWidth-1:0] dist_b;
	logic [PrioWidth-1:0] dist_r;

	function automatic logic [PrioWidth-1:0] dist_f(input logic [PrioWidth-1:0] p,
			input logic [PrioWidth-1:0] g);
		return (p > g) ? p - g : g - p;
	endfunction

	assign lidx   = {1'b0, cur_q, 1'b1};
	assign ridx   = lidx + IW'(1);
	assign par    = (cur_q - AW'(1)) >> 1;
	assign dist_x = dist_f(ent_x_q[EW-1 -: PrioWidth], grav_q);
	assign dist_b = dist_f(ent_b_q[EW-1 -: PrioWidth], grav_q);
	assign dist_r = dist_f(rd_q[EW-1 -: PrioWidth], grav_q);

	always_comb begin
		ra = '0;
		if (cmd.rd_par) begin
			ra = par;
		end else if (cmd.rd_left) begin
			ra = AW'(lidx);
		end else if (cmd.rd_right) begin
			ra = AW'(ridx);
		end else if (cmd.rem_last) begin
			ra = AW'(cnt_q - CW'(1));
		end else if (cmd.con_rd) begin
			ra = AW'(scan_q);
		end else if (cmd.rg_dec) begin
			ra = AW'(start_q - CW'(1));
		end
	end

	// The sifted entry X travels with a hole at cur and lands once at the end.
	assign we = cmd.wr_x | cmd.up_move | cmd.dn_move;

	always_comb begin
		wd = ent_b_q;
		if (cmd.wr_x) begin
			wd = ent_x_q;
		end else if (cmd.up_move) begin
			wd = rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[cur_q] <= wd;
		end
		rd_q <= mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			grav_q <= '0;
			op_q   <= OP_NOP6;
		end else begin
			if (cmd.load_req) begin
				op_q <= opcode_t'(opcode);
			end
			if (cmd.ins_setup) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd.rem_last) begin
				cnt_q <= cnt_q - CW'(1);
			end else if (cmd.clr) begin
				cnt_q <= '0;
			end
			if (cmd.rg_setup) begin
				grav_q <= ngrav_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			prio_q  <= priority_req;
			tag_q   <= TAG_WIDTH'(value_tag);
			ngrav_q <= new_gravity;
			found_q <= 1'b0;
			st_q    <= ST_OK;
			rtag_q  <= '0;
		end
		if (cmd.set_empty) begin
			st_q <= ST_EMPTY;
		end
		if (cmd.set_full) begin
			st_q <= ST_FULL;
		end
		if (cmd.take_tag) begin
			rtag_q <= rd_q[TAG_WIDTH-1:0];
		end
		if (cmd.ins_setup) begin
			ent_x_q <= {prio_q, tag_q};
			cur_q   <= AW'(cnt_q);
		end
		if (cmd.x_load) begin
			ent_x_q <= rd_q;
		end
		if (cmd.cur_root) begin
			cur_q <= '0;
		end
		if (cmd.cur_start) begin
			cur_q <= AW'(start_q);
		end
		if (cmd.up_move) begin
			cur_q <= par;
		end
		if (cmd.take_left) begin
			ent_b_q <= rd_q;
			pick_q  <= AW'(lidx);
		end
		if (cmd.take_right) begin
			ent_b_q <= rd_q;
			pick_q  <= AW'(ridx);
		end
		if (cmd.dn_move) begin
			cur_q <= pick_q;
		end
		if (cmd.con_setup) begin
			scan_q <= '0;
		end
		if (cmd.con_step) begin
			scan_q <= scan_q + CW'(1);
			if (rd_q[TAG_WIDTH-1:0] == tag_q) begin
				found_q <= 1'b1;
			end
		end
		if (cmd.rg_setup) begin
			start_q <= cnt_q;
		end
		if (cmd.rg_dec) begin
			start_q <= start_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			status     <= st_q;
			result_tag <= 32'(rtag_q);
			found      <= found_q;
			count      <= 7'(cnt_q);
		end
	end

	assign out_valid_set = cmd.out_load;

	always_comb begin
		sts.op           = op_q;
		sts.empty        = (cnt_q == '0);
		sts.full         = (cnt_q == CW'(CAPACITY));
		sts.cur_zero     = (cur_q == '0);
		sts.par_farther  = dist_r > dist_x;
		sts.has_left     = lidx < IW'(cnt_q);
		sts.has_right    = ridx < IW'(cnt_q);
		sts.right_closer = dist_r < dist_b;
		sts.x_farther    = dist_x > dist_b;
		sts.con_end      = (scan_q == cnt_q);
		sts.con_hit      = (rd_q[TAG_WIDTH-1:0] == tag_q);
		sts.rg_end       = (start_q == '0);
	end

endmodule

// ----- hw/rtl/ghpq_ctrl.sv -----
// ----------------------------------------------------------------------------
// ghpq_ctrl
// Sequencer for heap operations: sift up, sift down, scan and rebuild.
// ----------------------------------------------------------------------------
module ghpq_ctrl import ghpq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  logic      out_stall,
	output logic      out_valid,
	input  ghpq_sts_t sts,
	output ghpq_cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	state_t sift_end;
	logic   out_valid_q;

	assign out_valid = out_valid_q;
	assign in_stall  = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign sift_end  = (sts.op == OP_REGRAV) ? S_RG_NEXT : S_DONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && !in_stall) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (sts.op)
					OP_INSERT:  state_d = sts.full ? S_DONE : S_UP_RD;
					OP_REMOVE:  state_d = sts.empty ? S_DONE : S_REM_TAG;
					OP_PEEK:    state_d = sts.empty ? S_DONE : S_PEEK_TAG;
					OP_CONTAIN: state_d = S_CON_RD;
					OP_REGRAV:  state_d = S_RG_NEXT;
					default:    state_d = S_DONE;
				endcase
			end
			S_PEEK_TAG: state_d = S_DONE;
			S_REM_TAG:  state_d = S_REM_LOAD;
			S_REM_LOAD: state_d = S_DN_L;
			S_UP_RD:    state_d = sts.cur_zero ? S_DONE : S_UP_CMP;
			S_UP_CMP:   state_d = sts.par_farther ? S_UP_RD : S_DONE;
			S_DN_L:     state_d = sts.has_left ? S_DN_R : sift_end;
			S_DN_R:     state_d = S_DN_PICK;
			S_DN_PICK:  state_d = S_DN_CMP;
			S_DN_CMP:   state_d = sts.x_farther ? S_DN_L : sift_end;
			S_CON_RD:   state_d = sts.con_end ? S_DONE : S_CON_CMP;
			S_CON_CMP:  state_d = sts.con_hit ? S_DONE : S_CON_RD;
			S_RG_NEXT:  state_d = sts.rg_end ? S_DONE : S_RG_LOAD;
			S_RG_LOAD:  state_d = S_DN_L;
			S_DONE:     state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load_req = in_valid && !in_stall;
			end
			S_DECODE: begin
				unique case (sts.op)
					OP_INSERT: begin
						cmd.set_full  = sts.full;
						cmd.ins_setup = !sts.full;
					end
					OP_REMOVE:  cmd.set_empty = sts.empty;
					OP_PEEK:    cmd.set_empty = sts.empty;
					OP_CONTAIN: cmd.con_setup = 1'b1;
					OP_REGRAV:  cmd.rg_setup  = 1'b1;
					OP_CLEAR:   cmd.clr       = 1'b1;
					default: ;
				endcase
			end
			S_PEEK_TAG: begin
				cmd.take_tag = 1'b1;
			end
			S_REM_TAG: begin
				cmd.take_tag = 1'b1;
				cmd.rem_last = 1'b1;
			end
			S_REM_LOAD: begin
				cmd.x_load   = 1'b1;
				cmd.cur_root = 1'b1;
			end
			S_UP_RD: begin
				cmd.wr_x   = sts.cur_zero;
				cmd.rd_par = !sts.cur_zero;
			end
			S_UP_CMP: begin
				cmd.up_move = sts.par_farther;
				cmd.wr_x    = !sts.par_farther;
			end
			S_DN_L: begin
				cmd.rd_left = sts.has_left;
				cmd.wr_x    = !sts.has_left;
			end
			S_DN_R: begin
				cmd.take_left = 1'b1;
				cmd.rd_right  = sts.has_right;
			end
			S_DN_PICK: begin
				cmd.take_right = sts.has_right && sts.right_closer;
			end
			S_DN_CMP: begin
				cmd.dn_move = sts.x_farther;
				cmd.wr_x    = !sts.x_farther;
			end
			S_CON_RD: begin
				cmd.con_rd = !sts.con_end;
			end
			S_CON_CMP: begin
				cmd.con_step = 1'b1;
			end
			S_RG_NEXT: begin
				cmd.rg_dec = !sts.rg_end;
			end
			S_RG_LOAD: begin
				cmd.x_load    = 1'b1;
				cmd.cur_start = 1'b1;
			end
			S_DONE: begin
				cmd.out_load = 1'b1;
			end
			default: ;
		endcase
	end

endmodule

// ----- hw/rtl/gravity_heap_priority_queue.sv -----
// ----------------------------------------------------------------------------
// gravity_heap_priority_queue
// Binary heap ordered by distance from a stored gravity.
//
//   channel | handshake             | fields
//   in      | valid_in / stall_in   | opcode, priority_req, value_tag, new_gravity
//   out     | valid_out / stall_out | status, result_tag, found, count
//
// One request at a time. Insert sifts the new entry up the heap, remove
// sinks the last entry down from the root, peek reads the root tag,
// contains scans entries until a match, regravitate sinks every entry.
// Reset clears count and gravity; heap storage is not cleared.
// A stalled output request holds its fields and keeps stall_in high.
// ----------------------------------------------------------------------------
module gravity_heap_priority_queue import ghpq_pkg::*; #(
	parameter int unsigned CAPACITY  = DefCapacity,
	parameter int unsigned TAG_WIDTH = DefTagWidth
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid_in,
	output logic                 stall_in,
	input  logic [2:0]           opcode,
	input  logic [PrioWidth-1:0] priority_req,
	input  logic [31:0]          value_tag,
	input  logic [PrioWidth-1:0] new_gravity,
	output logic                 valid_out,
	input  logic                 stall_out,
	output logic [1:0]           status,
	output logic [31:0]          result_tag,
	output logic                 found,
	output logic [6:0]           count
);

	ghpq_cmd_t cmd;
	ghpq_sts_t sts;
	logic      ovs;

	ghpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_in),
		.in_stall  (stall_in),
		.out_stall (stall_out),
		.out_valid (valid_out),
		.sts       (sts),
		.cmd       (cmd)
	);

	ghpq_datapath #(
		.CAPACITY  (CAPACITY),
		.TAG_WIDTH (TAG_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.opcode        (opcode),
		.priority_req  (priority_req),
		.value_tag     (value_tag),
		.new_gravity   (new_gravity),
		.out_valid_set (ovs),
		.status        (status),
		.result_tag    (result_tag),
		.found         (found),
		.count         (count)
	);

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_out && stall_out) |-> stall_in)
		else $error("request accepted while output stalled");

	a_load_once: assert property (@(posedge clk) disable iff (!arst_n)
		ovs |=> !ovs)
		else $error("output loaded twice");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_out && stall_out) |=> (valid_out && $stable(status)
			&& $stable(result_tag) && $stable(found) && $stable(count)))
		else $error("stalled output changed");

endmodule

// ----- verif/tb_gravity_heap_priority_queue.sv -----
// ----------------------------------------------------------------------------
// tb_gravity_heap_priority_queue
// Self-checking bench for the gravity heap priority queue. A predictor keeps
// its own heap and gravity and computes each response from accepted requests.
// Directed requests cover the edge cases, then randomized fill, drain and
// mixed phases run with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_gravity_heap_priority_queue import ghpq_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned Depth    = 64;
	localparam int unsigned MaxCycle = 1000000;

	typedef struct {
		status_t     st;
		logic [31:0] tag;
		logic        hit;
		logic [6:0]  cnt;
	} resp_t;

	class heap_scoreboard;
		logic [63:0] prio[Depth];
		logic [31:0] tags[Depth];
		int unsigned fill;
		logic [63:0] grav;
		resp_t       waiting[$];
		int unsigned errors;

		function new();
			fill = 0;
			grav = '0;
			errors = 0;
		endfunction

		function logic [63:0] gap(int unsigned i);
			return prio[i] > grav ? prio[i] - grav : grav - prio[i];
		endfunction

		function void swap(int unsigned a, int unsigned b);
			logic [63:0] p;
			logic [31:0] t;
			p = prio[a]; prio[a] = prio[b]; prio[b] = p;
			t = tags[a]; tags[a] = tags[b]; tags[b] = t;
		endfunction

		function void sink(int unsigned i);
			int unsigned pick;
			while (2 * i + 1 < fill) begin
				pick = 2 * i + 1;
				if (pick + 1 < fill && gap(pick + 1) < gap(pick))
					pick = pick + 1;
				if (gap(i) > gap(pick)) begin
					swap(i, pick);
					i = pick;
				end else
					break;
			end
		endfunction

		function void rise(int unsigned i);
			int unsigned up;
			while (i != 0) begin
				up = (i - 1) / 2;
				if (gap(up) > gap(i)) begin
					swap(up, i);
					i = up;
				end else
					break;
			end
		endfunction

		function void note_request(opcode_t op, logic [63:0] p, logic [31:0] t,
				logic [63:0] g);
			resp_t r;
			r.st = ST_OK;
			r.tag = '0;
			r.hit = 1'b0;
			unique case (op)
				OP_INSERT: begin
					if (fill >= Depth)
						r.st = ST_FULL;
					else begin
						prio[fill] = p;
						tags[fill] = t;
						fill++;
						rise(fill - 1);
					end
				end
				OP_REMOVE: begin
					if (fill == 0)
						r.st = ST_EMPTY;
					else begin
						r.tag = tags[0];
						fill--;
						swap(0, fill);
						sink(0);
					end
				end
				OP_PEEK: begin
					if (fill == 0)
						r.st = ST_EMPTY;
					else
						r.tag = tags[0];
				end
				OP_CONTAIN: begin
					for (int unsigned i = 0; i < fill; i++)
						if (tags[i] == t)
							r.hit = 1'b1;
				end
				OP_REGRAV: begin
					grav = g;
					for (int unsigned i = fill; i > 0; i--)
						sink(i - 1);
				end
				OP_CLEAR: fill = 0;
				default: ;
			endcase
			r.cnt = fill[6:0];
			waiting.push_back(r);
		endfunction

		function void check_response(logic [1:0] st, logic [31:0] tag, logic hit,
				logic [6:0] cnt);
			resp_t r;
			if (waiting.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected response st=%0d tag=%h", st, tag);
				return;
			end
			r = waiting.pop_front();
			if (st !== r.st || tag !== r.tag || hit !== r.hit || cnt !== r.cnt) begin
				errors++;
				if (errors <= 10)
					$display({"mismatch: exp st=%0d tag=%h found=%b count=%0d,",
						" got st=%0d tag=%h found=%b count=%0d"},
						r.st, r.tag, r.hit, r.cnt, st, tag, hit, cnt);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        valid_in = 1'b0;
	logic        stall_in;
	logic [2:0]  opcode = '0;
	logic [63:0] priority_req = '0;
	logic [31:0] value_tag = '0;
	logic [63:0] new_gravity = '0;
	logic        valid_out;
	logic        stall_out = 1'b0;
	logic [1:0]  status;
	logic [31:0] result_tag;
	logic        found;
	logic [6:0]  count;

	heap_scoreboard sb = new();
	bit             calm = 1'b0;
	int unsigned    cycles = 0;

	gravity_heap_priority_queue i_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > MaxCycle) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(negedge clk)
		if (arst_n)
			stall_out <= calm ? 1'b0 : ($urandom_range(0, 99) < 34);

	always @(posedge clk)
		if (arst_n && valid_out && !stall_out)
			sb.check_response(status, result_tag, found, count);

	task automatic send(input opcode_t op, input logic [63:0] p, input logic [31:0] t,
			input logic [63:0] g);
		if (!calm && $urandom_range(0, 99) < 34) begin
			valid_in <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		valid_in <= 1'b1;
		opcode <= op;
		priority_req <= p;
		value_tag <= t;
		new_gravity <= g;
		forever begin
			@(posedge clk);
			if (!stall_in)
				break;
		end
		sb.note_request(op, p, t, g);
		@(negedge clk);
	endtask

	function automatic logic [63:0] rand_prio();
		logic [63:0] v;
		case ($urandom_range(0, 3))
			0: v = 64'($urandom_range(0, 7));
			1: v = '1 - 64'($urandom_range(0, 7));
			default: v = {$urandom, $urandom};
		endcase
		return v;
	endfunction

	function automatic logic [31:0] rand_tag();
		return $urandom_range(0, 1) ? 32'($urandom_range(0, 15)) : $urandom;
	endfunction

	task automatic random_request(input int unsigned mode);
		int unsigned r;
		opcode_t     op;
		r = $urandom_range(0, 99);
		if (r < 3)
			op = OP_REGRAV;
		else if (r < 5)
			op = OP_CLEAR;
		else if (r < 7)
			op = $urandom_range(0, 1) ? OP_NOP6 : OP_NOP7;
		else if (r < 17)
			op = OP_CONTAIN;
		else if (r < 25)
			op = OP_PEEK;
		else if (mode == 0)
			op = r < 85 ? OP_INSERT : OP_REMOVE;
		else if (mode == 1)
			op = r < 40 ? OP_INSERT : OP_REMOVE;
		else
			op = r < 62 ? OP_INSERT : OP_REMOVE;
		send(op, rand_prio(), rand_tag(), rand_prio());
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send(OP_PEEK, '0, '0, '0);
		send(OP_REMOVE, '0, '0, '0);
		send(OP_CONTAIN, '0, '0, '0);
		send(OP_INSERT, '1, 32'hFFFF_FFFF, '0);
		send(OP_INSERT, '0, 32'h0000_0000, '1);
		send(OP_INSERT, 64'd5, 32'hA5A5_5A5A, '0);
		send(OP_INSERT, 64'd5, 32'h1234_5678, '0);
		send(OP_PEEK, '0, '0, '0);
		send(OP_CONTAIN, '0, 32'hFFFF_FFFF, '0);
		send(OP_CONTAIN, '0, 32'h8000_0001, '0);
		send(OP_REGRAV, '0, '0, '1);
		send(OP_PEEK, '0, '0, '0);
		send(OP_REGRAV, '0, '0, 64'd5);
		send(OP_REMOVE, '0, '0, '0);
		send(OP_REMOVE, '0, '0, '0);
		send(OP_NOP6, '1, '1, '1);
		send(OP_NOP7, '0, '0, '0);
		send(OP_REGRAV, '0, '0, 64'h8000_0000_0000_0000);
		send(OP_REMOVE, '0, '0, '0);
		send(OP_CLEAR, '0, '0, '0);
		send(OP_REMOVE, '0, '0, '0);
		send(OP_REGRAV, '0, '0, '0);

		// fill to capacity, then one more
		for (int i = 0; i < 65; i++)
			send(OP_INSERT, rand_prio(), rand_tag(), '0);
		send(OP_REGRAV, '0, '0, {$urandom, $urandom});

		for (int i = 0; i < 360; i++) begin
			calm = (i >= 150 && i < 250);
			random_request((i / 40) % 3);
		end
		calm = 1'b0;
		valid_in <= 1'b0;

		while (sb.waiting.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
